// ----- rtl/core/counting_sort_descending_assert.svh -----
// Assertion macros shared by the sorter RTL.
`ifndef COUNTING_SORT_DESCENDING_ASSERT_SVH
`define COUNTING_SORT_DESCENDING_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CSD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger is followed by a result in the next cycle.
`define CSD_ASSERT_NEXT(label, trig, res, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (res)) \
        else $error(msg);

`endif

// ----- rtl/core/csd_pkg.sv -----
`timescale 1ns / 1ps

package csd_pkg;

    localparam int KEY_RANGE = 1024;
    localparam int MAX_ITEMS = 64;
    localparam int KEY_W     = 10;
    localparam int ADDR_W    = (KEY_RANGE > 1) ? $clog2(KEY_RANGE) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [KEY_W-1:0] key_value;
        logic             batch_end;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             final_key;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_INC,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/core/counting_sort_descending.sv -----
`timescale 1ns / 1ps
// Loading: ST_LOAD takes a key word and reads its count, then ST_INC writes back count + 1;
// no new word is accepted during the write-back. Emission: from the batch end, key slots
// are scanned from the largest key downward (ST_SCAN_RD, then ST_SCAN_EVAL), empty ones
// are skipped, and ST_EMIT emits each present key's words while the output is not stalled.
// The pace is set by the registered read port of the count memory. Reset (synchronous,
// active low) clears all KEY_RANGE (1024) count entries; no input word is accepted until it completes.

`include "counting_sort_descending_assert.svh"

module counting_sort_descending
    import csd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  mem [KEY_RANGE];
    logic [CNT_W-1:0]  r_rdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;

    logic [ADDR_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0] r_key, n_key;
    logic              r_inc, n_inc;
    logic              r_last, n_last;
    logic [KEY_W-1:0]  r_largest, n_largest;
    logic [CNT_W-1:0]  r_items, n_items;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic in_fire;
    logic emit_fire;
    logic key_ok;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_fire     = o_in_ready && i_in_valid;
    assign emit_fire   = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign key_ok      = (r_items < CNT_W'(MAX_ITEMS))
                         && (32'(i_in.key_value) < 32'(KEY_RANGE));
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Count memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_k == ADDR_W'(KEY_RANGE - 1)) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (in_fire) n_state = ST_INC;
            end
            ST_INC: begin
                if (r_last && (r_items != '0)) n_state = ST_SCAN_RD;
                else                           n_state = ST_LOAD;
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL: begin
                if (r_rdata == '0) n_state = ST_SCAN_RD;
                else               n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    if (r_left == CNT_W'(1))     n_state = ST_LOAD;
                    else if (r_cnt == CNT_W'(1)) n_state = ST_SCAN_RD;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_k         = r_k;
        n_key       = r_key;
        n_inc       = r_inc;
        n_last      = r_last;
        n_largest   = r_largest;
        n_items     = r_items;
        n_left      = r_left;
        n_cnt       = r_cnt;
        wr_en       = 1'b0;
        wr_addr     = r_k;
        wr_data     = '0;
        rd_addr     = (r_state == ST_LOAD) ? ADDR_W'(i_in.key_value) : r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            // sweep the count memory to zero
            ST_CLEAR: begin
                wr_en = 1'b1;
                n_k   = r_k + 1'b1;
            end
            // take a key word, track the largest key and the fill
            ST_LOAD: begin
                if (in_fire) begin
                    n_key  = ADDR_W'(i_in.key_value);
                    n_inc  = key_ok;
                    n_last = i_in.batch_end;
                    if (key_ok) begin
                        n_items = r_items + 1'b1;
                        if (i_in.key_value > r_largest) n_largest = i_in.key_value;
                    end
                end
            end
            // write back the incremented count of a valid key, start the scan at a non-empty batch end
            ST_INC: begin
                if (r_inc) begin
                    wr_en   = 1'b1;
                    wr_addr = r_key;
                    wr_data = r_rdata + 1'b1;
                end
                if (r_last) begin
                    n_k       = ADDR_W'(r_largest);
                    n_left    = r_items;
                    n_items   = '0;
                    n_largest = '0;
                end
            end
            // skip empty slots, latch a present count
            ST_SCAN_EVAL: begin
                n_cnt = r_rdata;
                if (r_rdata == '0) n_k = r_k - 1'b1;
            end
            // emit one word per count, clear the slot on its last word
            ST_EMIT: begin
                if (emit_fire) begin
                    n_out_valid      = 1'b1;
                    n_out.sorted_key = KEY_W'(r_k);
                    n_out.final_key  = (r_left == CNT_W'(1));
                    n_cnt            = r_cnt - 1'b1;
                    n_left           = r_left - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        wr_en = 1'b1;
                        n_k   = r_k - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_k         <= '0;
            r_largest   <= '0;
            r_items     <= '0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_largest   <= n_largest;
            r_items     <= n_items;
            r_left      <= n_left;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_inc  <= n_inc;
        r_last <= n_last;
        r_out  <= n_out;
    end

    `CSD_ASSERT_ALWAYS(a_fill_bound, r_items <= CNT_W'(MAX_ITEMS), "batch fill exceeds capacity")
    `CSD_ASSERT_ALWAYS(a_emit_nonzero, (r_state != ST_EMIT) || ((r_cnt != '0) && (r_left != '0)), "emitting with no count left")
    `CSD_ASSERT_NEXT(a_final_word, emit_fire && (r_left == CNT_W'(1)), o_out_valid && o_out.final_key && (r_state == ST_LOAD), "last word not marked final")
    `CSD_ASSERT_NEXT(a_scan_start, (r_state == ST_INC) && r_last, r_items == '0, "tracking not cleared at batch end")

endmodule
